>>> rtl/core/slru_page_cache_controller_top_defines.svh
// ============================================================================
// SLRU page cache controller assertion macros
// Immediate-style wrappers around concurrent properties, empty for synthesis.
// ============================================================================
`ifndef SLRU_PAGE_CACHE_CONTROLLER_TOP_DEFINES_SVH
`define SLRU_PAGE_CACHE_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check a condition in the same cycle as its trigger
`define SLRU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slru assertion failed");
// check a condition in the cycle after its trigger
`define SLRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slru assertion failed");
`else
`define SLRU_ASSERT_NOW(label, clk, rst, ante, cons)
`define SLRU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/core/slru_pkg.sv
// ============================================================================
// SLRU package
// Field widths, codes and the row command type shared by the cache engine.
// ============================================================================
package slru_pkg;

   // field widths
   localparam int OP_W     = 2;
   localparam int OBJ_W    = 32;
   localparam int OFF_W    = 64;
   localparam int SLOT_W   = 6;
   localparam int STAT_W   = 2;
   localparam int CNTR_W   = 32;
   localparam int TAG_W    = OBJ_W + OFF_W;
   localparam int FRM_W    = 7;
   localparam int FSIZE_W  = 21;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W    = 21;

   // register reset values
   localparam logic [FRM_W-1:0]   FRAMES_RESET = 7'd64;
   localparam logic [FSIZE_W-1:0] FSIZE_RESET  = 21'd4096;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FSIZE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKETS = 2'd2;

   // opcodes
   localparam logic [OP_W-1:0] OP_GET      = 2'd0;
   localparam logic [OP_W-1:0] OP_PUT      = 2'd1;
   localparam logic [OP_W-1:0] OP_PREFETCH = 2'd2;

   // result status
   localparam logic [STAT_W-1:0] ST_HIT     = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISS    = 2'd1;
   localparam logic [STAT_W-1:0] ST_PINNED  = 2'd2;
   localparam logic [STAT_W-1:0] ST_BAD_PUT = 2'd3;

   // segments
   localparam logic SEG_PROB = 1'b0;
   localparam logic SEG_PROT = 1'b1;

   // cell operations
   localparam logic [1:0] CELL_NOP  = 2'd0;
   localparam logic [1:0] CELL_MOVE = 2'd1;
   localparam logic [1:0] CELL_INC  = 2'd2;
   localparam logic [1:0] CELL_DEC  = 2'd3;

   // cell select modes
   localparam logic [1:0] SEL_ID     = 2'd0;
   localparam logic [1:0] SEL_FREE   = 2'd1;
   localparam logic [1:0] SEL_OLDEST = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] mode;
      logic       key_seg;
      logic       new_seg;
      logic       set_pin1;
   } row_cmd_type;

   typedef struct packed {
      logic found;
      logic sel_seg;
   } row_stat_type;

endpackage

>>> rtl/core/slru_ifs.sv
// ============================================================================
// SLRU channel interfaces
// Valid/ready request and response channels with their payload words.
// ============================================================================
interface slru_req_if;
   logic                         valid;
   logic                         ready;
   logic [slru_pkg::OP_W-1:0]    opcode;
   logic [slru_pkg::OBJ_W-1:0]   object_key;
   logic [slru_pkg::OFF_W-1:0]   byte_offset;
   logic [slru_pkg::SLOT_W-1:0]  release_slot;

   modport source (output valid, opcode, object_key, byte_offset, release_slot,
                   input ready);
   modport sink (input valid, opcode, object_key, byte_offset, release_slot,
                 output ready);
endinterface

interface slru_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [slru_pkg::STAT_W-1:0]  status;
   logic [slru_pkg::SLOT_W-1:0]  frame_slot;
   logic                         evicted;
   logic [slru_pkg::CNTR_W-1:0]  hit_total;
   logic [slru_pkg::CNTR_W-1:0]  miss_total;
   logic [slru_pkg::CNTR_W-1:0]  eviction_total;

   modport source (output valid, status, frame_slot, evicted, hit_total, miss_total,
                   eviction_total, input ready);
   modport sink (input valid, status, frame_slot, evicted, hit_total, miss_total,
                 eviction_total, output ready);
endinterface

>>> rtl/core/slru_cell.sv
// ============================================================================
// SLRU recency cell
// One position of the recency row: frame id, segment and pin count.
// ============================================================================
module slru_cell #(
   parameter int ID_W     = 6,
   parameter int PIN_BITS = 16,
   parameter int INDEX    = 0
) (
   input  logic                   clock,
   input  logic                   clear,
   input  logic                   active,
   input  logic                   is_top,
   input  slru_pkg::row_cmd_type  cmd,
   input  logic [ID_W-1:0]        key_id,
   input  logic [ID_W-1:0]        move_id,
   input  logic [PIN_BITS-1:0]    move_pin,
   input  logic                   seen_in,
   input  logic [ID_W-1:0]        up_id,
   input  logic                   up_seg,
   input  logic [PIN_BITS-1:0]    up_pin,
   output logic [ID_W-1:0]        id,
   output logic                   seg,
   output logic [PIN_BITS-1:0]    pin,
   output logic                   sel,
   output logic                   seen_out
);
   import slru_pkg::*;

   localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

   logic [ID_W-1:0]     id_ff, id_in;
   logic                seg_ff, seg_in;
   logic [PIN_BITS-1:0] pin_ff, pin_in;
   logic                cond;

   // match this cell against the command key
   always_comb begin
      unique case (cmd.mode)
         SEL_ID:     cond = active && (id_ff == key_id);
         SEL_FREE:   cond = active && (seg_ff == cmd.key_seg) && (pin_ff == '0);
         SEL_OLDEST: cond = active && (seg_ff == cmd.key_seg);
         default:    cond = 1'b0;
      endcase
   end

   // first match from the old end wins; everything at or above it shifts
   assign sel      = cond && !seen_in;
   assign seen_out = seen_in || cond;

   always_comb begin
      id_in  = id_ff;
      seg_in = seg_ff;
      pin_in = pin_ff;
      unique case (cmd.op)
         CELL_NOP: begin
         end
         CELL_MOVE: begin
            if (active && seen_out) begin
               if (is_top) begin
                  id_in  = move_id;
                  seg_in = cmd.new_seg;
                  pin_in = cmd.set_pin1 ? PIN_BITS'(1) : move_pin;
               end else begin
                  id_in  = up_id;
                  seg_in = up_seg;
                  pin_in = up_pin;
               end
            end
         end
         CELL_INC: begin
            if (sel && pin_ff != PIN_MAX) pin_in = pin_ff + PIN_BITS'(1);
         end
         CELL_DEC: begin
            if (sel && pin_ff != '0) pin_in = pin_ff - PIN_BITS'(1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         id_ff  <= ID_W'(INDEX);
         seg_ff <= SEG_PROB;
         pin_ff <= '0;
      end else begin
         id_ff  <= id_in;
         seg_ff <= seg_in;
         pin_ff <= pin_in;
      end
   end

   assign id  = id_ff;
   assign seg = seg_ff;
   assign pin = pin_ff;

endmodule

>>> rtl/core/slru_row.sv
// ============================================================================
// SLRU recency row
// Chain of cells ordered from the old end, with the select result gathered.
// ============================================================================
module slru_row #(
   parameter int FRAMES   = 64,
   parameter int ID_W     = 6,
   parameter int CNT_W    = 7,
   parameter int PIN_BITS = 16
) (
   input  logic                   clock,
   input  logic                   clear,
   input  logic [CNT_W-1:0]       n_frames,
   input  slru_pkg::row_cmd_type  cmd,
   input  logic [ID_W-1:0]        key_id,
   output slru_pkg::row_stat_type stat,
   output logic [ID_W-1:0]        sel_id,
   output logic [PIN_BITS-1:0]    sel_pin
);
   import slru_pkg::*;

   logic [ID_W-1:0]     id_w  [FRAMES];
   logic [PIN_BITS-1:0] pin_w [FRAMES];
   logic [FRAMES-1:0]   seg_w;
   logic [FRAMES-1:0]   sel_w;
   logic [FRAMES:0]     seen_w;
   logic                sel_seg;

   assign seen_w[0] = 1'b0;

   // build the chain, each cell handing its entry down to the older neighbor
   for (genvar g = 0; g < FRAMES; g++) begin : g_cell
      logic [ID_W-1:0]     up_id;
      logic                up_seg;
      logic [PIN_BITS-1:0] up_pin;
      if (g == FRAMES - 1) begin : g_end
         assign up_id  = '0;
         assign up_seg = SEG_PROB;
         assign up_pin = '0;
      end else begin : g_mid
         assign up_id  = id_w[g+1];
         assign up_seg = seg_w[g+1];
         assign up_pin = pin_w[g+1];
      end
      slru_cell #(
         .ID_W     (ID_W),
         .PIN_BITS (PIN_BITS),
         .INDEX    (g)
      ) u_cell (
         .clock    (clock),
         .clear    (clear),
         .active   (CNT_W'(g) < n_frames),
         .is_top   (CNT_W'(g) == n_frames - CNT_W'(1)),
         .cmd      (cmd),
         .key_id   (key_id),
         .move_id  (sel_id),
         .move_pin (sel_pin),
         .seen_in  (seen_w[g]),
         .up_id    (up_id),
         .up_seg   (up_seg),
         .up_pin   (up_pin),
         .id       (id_w[g]),
         .seg      (seg_w[g]),
         .pin      (pin_w[g]),
         .sel      (sel_w[g]),
         .seen_out (seen_w[g+1])
      );
   end

   // gather the single selected entry
   always_comb begin
      sel_id  = '0;
      sel_pin = '0;
      sel_seg = 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
         sel_id  = sel_id  | (id_w[i]  & {ID_W{sel_w[i]}});
         sel_pin = sel_pin | (pin_w[i] & {PIN_BITS{sel_w[i]}});
         sel_seg = sel_seg | (seg_w[i] & sel_w[i]);
      end
   end

   assign stat.found   = seen_w[FRAMES];
   assign stat.sel_seg = sel_seg;

endmodule

>>> rtl/core/slru_rem_unit.sv
// ============================================================================
// SLRU remainder unit
// Restoring remainder of the byte offset by the frame size, one bit a cycle.
// ============================================================================
module slru_rem_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [slru_pkg::OFF_W-1:0]    dividend,
   input  logic [slru_pkg::FSIZE_W-1:0]  divisor,
   output logic                          done,
   output logic [slru_pkg::FSIZE_W-1:0]  remainder
);
   import slru_pkg::*;

   localparam int CNT_W = $clog2(OFF_W);

   logic [OFF_W-1:0]   num_ff;
   logic [FSIZE_W-1:0] div_ff;
   logic [FSIZE_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic               run_ff;
   logic               done_ff;
   logic [FSIZE_W:0]   shifted;

   // shift in one dividend bit and subtract when it fits
   always_comb begin
      shifted = {rem_ff, num_ff[OFF_W-1]};
      if (shifted >= {1'b0, div_ff}) begin
         rem_in = FSIZE_W'(shifted - {1'b0, div_ff});
      end else begin
         rem_in = shifted[FSIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(OFF_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
      end else if (run_ff) begin
         num_ff <= {num_ff[OFF_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/core/slru_page_cache_controller_top.sv
// ============================================================================
// SLRU page cache controller
// Tag store and segmented LRU replacement engine for a page cache.
// ============================================================================
//
//   channel  dir  word
//   req      in   opcode, object_key, byte_offset, release_slot
//   rsp      out  status, frame_slot, evicted, hit_total, miss_total,
//                 eviction_total
//   csr      in   write enable, register index, write data
//
// A put runs S_PUT then S_FIN. A get or prefetch runs the offset remainder
// (S_DIV, one bit a cycle), the tag scan (S_LOOK, one frame a cycle through
// the tag memory read port), the recency row moves and S_FIN.
// Reset and register writes clear the cache state; no clearing pass.
// One request is worked at a time; a stalled response holds the engine in
// its final state, while a response word waiting in the output register
// does not stop the next request from being accepted.
//
`include "slru_page_cache_controller_top_defines.svh"

module slru_page_cache_controller_top #(
   parameter int FRAMES   = 64,
   parameter int PIN_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   slru_req_if.sink                        req,
   slru_rsp_if.source                      rsp,
   input  logic                            csr_write_enable,
   input  logic [slru_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [slru_pkg::CSR_W-1:0]      csr_write_data
);
   import slru_pkg::*;

   localparam int ID_W  = $clog2(FRAMES);
   localparam int CNT_W = $clog2(FRAMES + 1);
   localparam int CW    = CNT_W + 3;
   localparam int FW    = (CNT_W > FRM_W) ? CNT_W : FRM_W;
   localparam int RW    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DIV      = 4'd1;
   localparam logic [3:0] S_LOOK     = 4'd2;
   localparam logic [3:0] S_HIT_PIN  = 4'd3;
   localparam logic [3:0] S_HIT_DEM  = 4'd4;
   localparam logic [3:0] S_HIT_PRO  = 4'd5;
   localparam logic [3:0] S_VIC_PROB = 4'd6;
   localparam logic [3:0] S_VIC_PROT = 4'd7;
   localparam logic [3:0] S_UNPIN    = 4'd8;
   localparam logic [3:0] S_PUT      = 4'd9;
   localparam logic [3:0] S_FIN      = 4'd10;

   // configuration
   logic [FRM_W-1:0]   cfg_frames_ff;
   logic [FSIZE_W-1:0] cfg_fsize_ff;
   logic [CNT_W-1:0]   n_eff;
   logic [FSIZE_W-1:0] fsize_eff;
   logic               csr_hit;
   logic               rebuild;

   // engine state
   logic [3:0]         state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [OBJ_W-1:0]   obj_ff, obj_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [SLOT_W-1:0]  rel_ff, rel_in;
   logic [OFF_W-1:0]   aligned_ff, aligned_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               pend_ff, pend_in;
   logic [ID_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [TAG_W-1:0]   rd_data_ff;
   logic [ID_W-1:0]    slot_ff, slot_in;
   logic               fseg_ff, fseg_in;
   logic [STAT_W-1:0]  res_stat_ff, res_stat_in;
   logic               res_ev_ff, res_ev_in;
   logic [FRAMES-1:0]  valid_ff, valid_in;
   logic [CNT_W-1:0]   pt_ff, pt_in;
   logic [CNTR_W-1:0]  hit_ff, hit_in;
   logic [CNTR_W-1:0]  miss_ff, miss_in;
   logic [CNTR_W-1:0]  evc_ff, evc_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_stat_ff, rsp_stat_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic               rsp_ev_ff, rsp_ev_in;
   logic [CNTR_W-1:0]  rsp_hit_ff, rsp_hit_in;
   logic [CNTR_W-1:0]  rsp_miss_ff, rsp_miss_in;
   logic [CNTR_W-1:0]  rsp_evc_ff, rsp_evc_in;

   // tag memory
   logic [TAG_W-1:0]   tag_mem [FRAMES];
   logic               mem_we;
   logic [ID_W-1:0]    mem_waddr;

   // row and remainder unit
   row_cmd_type        cmd;
   logic [ID_W-1:0]    key_id;
   row_stat_type       row_stat;
   logic [ID_W-1:0]    row_sel_id;
   logic [PIN_BITS-1:0] row_sel_pin;
   logic               div_start;
   logic               div_done;
   logic [FSIZE_W-1:0] div_rem;

   logic               req_take;
   logic               cap_full;
   logic               rel_in_range;
   logic               tag_match;

   // effective register values
   always_comb begin
      if (cfg_frames_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (FW'(cfg_frames_ff) > FW'(FRAMES)) begin
         n_eff = CNT_W'(FRAMES);
      end else begin
         n_eff = CNT_W'(cfg_frames_ff);
      end
      fsize_eff = (cfg_fsize_ff == '0) ? FSIZE_W'(1) : cfg_fsize_ff;
   end

   assign csr_hit = csr_write_enable &&
                    (csr_index == CSR_FRAMES || csr_index == CSR_FSIZE ||
                     csr_index == CSR_BUCKETS);
   assign rebuild = reset || csr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_frames_ff <= FRAMES_RESET;
         cfg_fsize_ff  <= FSIZE_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_FRAMES)     cfg_frames_ff <= csr_write_data[FRM_W-1:0];
         else if (csr_index == CSR_FSIZE) cfg_fsize_ff  <= csr_write_data[FSIZE_W-1:0];
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign req_take  = req.valid && req.ready;

   // protected segment at its share: floor(3n/4) <= total
   assign cap_full     = (CW'(pt_ff) + CW'(1)) * CW'(4) > CW'(n_eff) * CW'(3);
   assign rel_in_range = RW'(rel_ff) < RW'(n_eff);
   assign tag_match    = pend_ff && valid_ff[rd_idx_ff] &&
                         (rd_data_ff == {obj_ff, aligned_ff});

   slru_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req.byte_offset),
      .divisor   (fsize_eff),
      .done      (div_done),
      .remainder (div_rem)
   );

   slru_row #(
      .FRAMES   (FRAMES),
      .ID_W     (ID_W),
      .CNT_W    (CNT_W),
      .PIN_BITS (PIN_BITS)
   ) u_row (
      .clock    (clock),
      .clear    (rebuild),
      .n_frames (n_eff),
      .cmd      (cmd),
      .key_id   (key_id),
      .stat     (row_stat),
      .sel_id   (row_sel_id),
      .sel_pin  (row_sel_pin)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      obj_in      = obj_ff;
      off_in      = off_ff;
      rel_in      = rel_ff;
      aligned_in  = aligned_ff;
      scan_in     = scan_ff;
      pend_in     = pend_ff;
      rd_idx_in   = rd_idx_ff;
      slot_in     = slot_ff;
      fseg_in     = fseg_ff;
      res_stat_in = res_stat_ff;
      res_ev_in   = res_ev_ff;
      valid_in    = valid_ff;
      pt_in       = pt_ff;
      hit_in      = hit_ff;
      miss_in     = miss_ff;
      evc_in      = evc_ff;
      cmd         = '{op: CELL_NOP, mode: SEL_ID, key_seg: SEG_PROB,
                      new_seg: SEG_PROB, set_pin1: 1'b0};
      key_id      = slot_ff;
      mem_we      = 1'b0;
      mem_waddr   = row_sel_id;
      div_start   = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_miss_in  = rsp_miss_ff;
      rsp_evc_in   = rsp_evc_ff;

      unique case (state_ff) inside
         S_IDLE: begin
            if (req_take) begin
               op_in     = req.opcode;
               obj_in    = req.object_key;
               off_in    = req.byte_offset;
               rel_in    = req.release_slot;
               res_ev_in = 1'b0;
               slot_in   = '0;
               if (req.opcode == OP_PUT) begin
                  state_in = S_PUT;
               end else if (req.opcode == OP_GET || req.opcode == OP_PREFETCH) begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end else begin
                  res_stat_in = ST_BAD_PUT;
                  state_in    = S_FIN;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               aligned_in = off_ff - OFF_W'(div_rem);
               scan_in    = '0;
               pend_in    = 1'b0;
               state_in   = S_LOOK;
            end
         end
         S_LOOK: begin
            // one tag read issued per cycle, compared the cycle after
            if (tag_match) begin
               slot_in  = rd_idx_ff;
               hit_in   = hit_ff + CNTR_W'(1);
               pend_in  = 1'b0;
               state_in = S_HIT_PIN;
            end else if (!pend_ff && scan_ff >= n_eff) begin
               miss_in  = miss_ff + CNTR_W'(1);
               state_in = S_VIC_PROB;
            end else if (scan_ff < n_eff) begin
               rd_idx_in = scan_ff[ID_W-1:0];
               scan_in   = scan_ff + CNT_W'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         S_HIT_PIN: begin
            cmd.op      = CELL_INC;
            cmd.mode    = SEL_ID;
            fseg_in     = row_stat.sel_seg;
            res_stat_in = ST_HIT;
            state_in    = S_HIT_DEM;
         end
         S_HIT_DEM: begin
            if (fseg_ff == SEG_PROT) begin
               cmd.op      = CELL_MOVE;
               cmd.mode    = SEL_ID;
               cmd.new_seg = SEG_PROT;
               state_in    = (op_ff == OP_PREFETCH) ? S_UNPIN : S_FIN;
            end else begin
               // demote the oldest protected frame when the segment is full
               if (cap_full) begin
                  cmd.op      = CELL_MOVE;
                  cmd.mode    = SEL_OLDEST;
                  cmd.key_seg = SEG_PROT;
                  cmd.new_seg = SEG_PROB;
                  if (row_stat.found && pt_ff != '0) pt_in = pt_ff - CNT_W'(1);
               end
               state_in = S_HIT_PRO;
            end
         end
         S_HIT_PRO: begin
            cmd.op      = CELL_MOVE;
            cmd.mode    = SEL_ID;
            cmd.new_seg = SEG_PROT;
            pt_in       = pt_ff + CNT_W'(1);
            state_in    = (op_ff == OP_PREFETCH) ? S_UNPIN : S_FIN;
         end
         S_VIC_PROB, S_VIC_PROT: begin
            cmd.op       = CELL_MOVE;
            cmd.mode     = SEL_FREE;
            cmd.key_seg  = (state_ff == S_VIC_PROT) ? SEG_PROT : SEG_PROB;
            cmd.new_seg  = SEG_PROB;
            cmd.set_pin1 = 1'b1;
            if (row_stat.found) begin
               // re-key the victim and report it for loading
               mem_we      = 1'b1;
               slot_in     = row_sel_id;
               res_stat_in = ST_MISS;
               res_ev_in   = valid_ff[row_sel_id];
               if (valid_ff[row_sel_id]) evc_in = evc_ff + CNTR_W'(1);
               valid_in[row_sel_id] = 1'b1;
               if (state_ff == S_VIC_PROT && pt_ff != '0) pt_in = pt_ff - CNT_W'(1);
               state_in = (op_ff == OP_PREFETCH) ? S_UNPIN : S_FIN;
            end else if (state_ff == S_VIC_PROB) begin
               state_in = S_VIC_PROT;
            end else begin
               res_stat_in = ST_PINNED;
               slot_in     = '0;
               state_in    = S_FIN;
            end
         end
         S_UNPIN: begin
            cmd.op   = CELL_DEC;
            cmd.mode = SEL_ID;
            state_in = S_FIN;
         end
         S_PUT: begin
            key_id   = ID_W'(rel_ff);
            cmd.mode = SEL_ID;
            cmd.op   = rel_in_range ? CELL_DEC : CELL_NOP;
            if (rel_in_range && row_stat.found && row_sel_pin != '0) begin
               res_stat_in = ST_HIT;
            end else begin
               res_stat_in = ST_BAD_PUT;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = res_stat_ff;
               rsp_slot_in  = (op_ff == OP_PUT) ? rel_ff : SLOT_W'(slot_ff);
               rsp_ev_in    = res_ev_ff;
               rsp_hit_in   = hit_ff;
               rsp_miss_in  = miss_ff;
               rsp_evc_in   = evc_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // cache state restored on reset and on register writes
   always_ff @(posedge clock) begin
      if (rebuild) begin
         valid_ff <= '0;
         pt_ff    <= '0;
         hit_ff   <= '0;
         miss_ff  <= '0;
         evc_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pt_ff    <= pt_in;
         hit_ff   <= hit_in;
         miss_ff  <= miss_in;
         evc_ff   <= evc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      obj_ff      <= obj_in;
      off_ff      <= off_in;
      rel_ff      <= rel_in;
      aligned_ff  <= aligned_in;
      scan_ff     <= scan_in;
      rd_idx_ff   <= rd_idx_in;
      slot_ff     <= slot_in;
      fseg_ff     <= fseg_in;
      res_stat_ff <= res_stat_in;
      res_ev_ff   <= res_ev_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_miss_ff <= rsp_miss_in;
      rsp_evc_ff  <= rsp_evc_in;
   end

   // tag memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) tag_mem[mem_waddr] <= {obj_ff, aligned_ff};
      rd_data_ff <= tag_mem[rd_idx_in];
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_stat_ff;
   assign rsp.frame_slot     = rsp_slot_ff;
   assign rsp.evicted        = rsp_ev_ff;
   assign rsp.hit_total      = rsp_hit_ff;
   assign rsp.miss_total     = rsp_miss_ff;
   assign rsp.eviction_total = rsp_evc_ff;

   `SLRU_ASSERT_NOW(a_prot_bound, clock, reset, 1'b1, pt_ff <= n_eff)
   `SLRU_ASSERT_NEXT(a_take_busy, clock, reset, req_take, state_ff != S_IDLE)
   `SLRU_ASSERT_NOW(a_div_state, clock, reset, div_done, state_ff == S_DIV)

endmodule

>>> verif/tb_slru_page_cache_controller_top.sv
`timescale 1ns / 1ps
// ============================================================================
// SLRU page cache controller testbench
// Drives get, put, prefetch and undefined opcode words through several frame,
// page size and bucket settings and checks every response word against a
// segmented LRU tag and recency model kept in the scoreboard.
// ============================================================================

typedef struct {
   logic [slru_pkg::STAT_W-1:0] status;
   logic [slru_pkg::SLOT_W-1:0] frame_slot;
   logic                        evicted;
   logic [31:0]                 hit_total;
   logic [31:0]                 miss_total;
   logic [31:0]                 eviction_total;
} cache_result_type;

class cache_scoreboard;
   localparam int NFR  = 64;
   localparam int NBK  = 64;
   localparam int NONE = 255;
   localparam int PIN_LIMIT = 65535;

   int          frames_reg;
   int          fsize_reg;
   int          buckets_reg;
   logic [31:0] tag_obj [NFR];
   logic [63:0] tag_off [NFR];
   bit          live [NFR];
   int          pins [NFR];
   bit          seg [NFR];
   int          older [NFR];
   int          newer [NFR];
   int          chain [NFR];
   int          heads [NBK];
   int          ends [2][2];   // [segment][0 = MRU, 1 = LRU]
   int          prot_count;
   logic [31:0] hits, misses, evictions;
   cache_result_type expected_words[$];
   int          mismatches;

   function new();
      frames_reg = 64;
      fsize_reg = 4096;
      buckets_reg = 64;
      mismatches = 0;
      rebuild();
   endfunction

   function int num_frames();
      if (frames_reg == 0) return 1;
      return frames_reg > NFR ? NFR : frames_reg;
   endfunction

   function int num_buckets();
      if (buckets_reg == 0) return 1;
      return buckets_reg > NBK ? NBK : buckets_reg;
   endfunction

   function logic [63:0] page_bytes();
      return fsize_reg == 0 ? 64'd1 : 64'(fsize_reg);
   endfunction

   function void detach(int f, int s);
      int p, n;
      p = newer[f];
      n = older[f];
      if (p < NFR) older[p] = n;
      else if (ends[s][0] == f) ends[s][0] = n;
      if (n < NFR) newer[n] = p;
      else if (ends[s][1] == f) ends[s][1] = p;
   endfunction

   function void push_front(int f, int s);
      newer[f] = NONE;
      older[f] = ends[s][0];
      if (ends[s][0] < NFR) newer[ends[s][0]] = f;
      ends[s][0] = f;
      if (ends[s][1] >= NFR) ends[s][1] = f;
   endfunction

   function int bucket_of(logic [31:0] obj, logic [63:0] aligned);
      logic [31:0] pg, mix;
      pg = 32'(aligned / page_bytes());
      mix = (obj * 32'd2654435761) ^ (pg * 32'd40503);
      return int'(mix % 32'(num_buckets()));
   endfunction

   function void rebuild();
      for (int i = 0; i < NFR; i++) begin
         tag_obj[i] = '0;
         tag_off[i] = '0;
         live[i] = 0;
         pins[i] = 0;
         seg[i] = slru_pkg::SEG_PROB;
         older[i] = NONE;
         newer[i] = NONE;
         chain[i] = NONE;
      end
      for (int i = 0; i < NBK; i++) heads[i] = NONE;
      ends = '{'{NONE, NONE}, '{NONE, NONE}};
      prot_count = 0;
      hits = 0;
      misses = 0;
      evictions = 0;
      for (int i = 0; i < num_frames(); i++) push_front(i, slru_pkg::SEG_PROB);
   endfunction

   function void write_reg(logic [1:0] idx, logic [20:0] val);
      case (idx)
         slru_pkg::CSR_FRAMES: frames_reg = int'(val[6:0]);
         slru_pkg::CSR_FSIZE: fsize_reg = int'(val);
         slru_pkg::CSR_BUCKETS: buckets_reg = int'(val[6:0]);
         default: return;
      endcase
      rebuild();
   endfunction

   function void unlink_chain(int f);
      int b, cur;
      b = bucket_of(tag_obj[f], tag_off[f]);
      cur = heads[b];
      if (cur == f) begin
         heads[b] = chain[f];
      end else begin
         for (int k = 0; k < NFR && cur < NFR; k++) begin
            if (chain[cur] == f) begin
               chain[cur] = chain[f];
               break;
            end
            cur = chain[cur];
         end
      end
      chain[f] = NONE;
   endfunction

   function int first_free(int tail);
      int cur;
      cur = tail;
      for (int k = 0; k < NFR && cur < NFR; k++) begin
         if (pins[cur] == 0) return cur;
         cur = newer[cur];
      end
      return NONE;
   endfunction

   // move a hit frame to the protected MRU end, demoting when full
   function void promote(int f);
      int cap, d;
      cap = (num_frames() * 75) / 100;
      if (seg[f] == slru_pkg::SEG_PROT) begin
         detach(f, slru_pkg::SEG_PROT);
         push_front(f, slru_pkg::SEG_PROT);
         return;
      end
      detach(f, slru_pkg::SEG_PROB);
      if (prot_count >= cap) begin
         d = ends[slru_pkg::SEG_PROT][1];
         if (d < NFR) begin
            detach(d, slru_pkg::SEG_PROT);
            seg[d] = slru_pkg::SEG_PROB;
            push_front(d, slru_pkg::SEG_PROB);
            if (prot_count > 0) prot_count--;
         end
      end
      seg[f] = slru_pkg::SEG_PROT;
      push_front(f, slru_pkg::SEG_PROT);
      prot_count++;
   endfunction

   function logic [1:0] lookup_and_pin(logic [31:0] obj, logic [63:0] off,
                                       output int slot, output bit ev);
      logic [63:0] aligned;
      int f, v, b, cur;
      aligned = off - (off % page_bytes());
      slot = 0;
      ev = 0;
      f = NONE;
      cur = heads[bucket_of(obj, aligned)];
      for (int k = 0; k < NFR && cur < NFR; k++) begin
         if (live[cur] && tag_obj[cur] == obj && tag_off[cur] == aligned) begin
            f = cur;
            break;
         end
         cur = chain[cur];
      end
      if (f < NFR) begin
         hits++;
         if (pins[f] < PIN_LIMIT) pins[f]++;
         promote(f);
         slot = f;
         return slru_pkg::ST_HIT;
      end
      misses++;
      v = first_free(ends[slru_pkg::SEG_PROB][1]);
      if (v >= NFR) v = first_free(ends[slru_pkg::SEG_PROT][1]);
      if (v >= NFR) return slru_pkg::ST_PINNED;
      if (live[v]) begin
         unlink_chain(v);
         evictions++;
         ev = 1;
      end
      if (seg[v] == slru_pkg::SEG_PROT) begin
         detach(v, slru_pkg::SEG_PROT);
         if (prot_count > 0) prot_count--;
      end else begin
         detach(v, slru_pkg::SEG_PROB);
      end
      tag_obj[v] = obj;
      tag_off[v] = aligned;
      live[v] = 1;
      pins[v] = 1;
      seg[v] = slru_pkg::SEG_PROB;
      b = bucket_of(obj, aligned);
      chain[v] = heads[b];
      heads[b] = v;
      push_front(v, slru_pkg::SEG_PROB);
      slot = v;
      return slru_pkg::ST_MISS;
   endfunction

   function logic [1:0] unpin(int slot);
      if (slot >= num_frames() || pins[slot] == 0) return slru_pkg::ST_BAD_PUT;
      pins[slot]--;
      return slru_pkg::ST_HIT;
   endfunction

   // predict the response to an accepted request word and queue it
   function cache_result_type note_request(logic [1:0] op, logic [31:0] obj,
                                           logic [63:0] off, logic [5:0] rel);
      cache_result_type r;
      int slot;
      bit ev;
      logic [1:0] st;
      slot = 0;
      ev = 0;
      st = slru_pkg::ST_BAD_PUT;
      if (op == slru_pkg::OP_GET) begin
         st = lookup_and_pin(obj, off, slot, ev);
      end else if (op == slru_pkg::OP_PUT) begin
         st = unpin(int'(rel));
         slot = int'(rel);
      end else if (op == slru_pkg::OP_PREFETCH) begin
         st = lookup_and_pin(obj, off, slot, ev);
         if (st != slru_pkg::ST_PINNED) void'(unpin(slot));
      end
      r.status = st;
      r.frame_slot = 6'(slot);
      r.evicted = ev;
      r.hit_total = hits;
      r.miss_total = misses;
      r.eviction_total = evictions;
      expected_words.push_back(r);
      return r;
   endfunction

   // compare one response word with the oldest prediction
   function void check_response(cache_result_type got);
      cache_result_type want;
      if (expected_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: unexpected response word status=%0d slot=%0d",
                     got.status, got.frame_slot);
         return;
      end
      want = expected_words.pop_front();
      if (got.status !== want.status || got.frame_slot !== want.frame_slot ||
          got.evicted !== want.evicted || got.hit_total !== want.hit_total ||
          got.miss_total !== want.miss_total ||
          got.eviction_total !== want.eviction_total) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
                     want.status, want.frame_slot, want.evicted, want.hit_total,
                     want.miss_total, want.eviction_total, got.status, got.frame_slot,
                     got.evicted, got.hit_total, got.miss_total, got.eviction_total);
      end
   endfunction
endclass

module tb_slru_page_cache_controller_top;
   import slru_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam logic [1:0] OP_NONE = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_write_data;
   int                   cycle_count;
   bit                   quiet;
   int                   held_slots[$];
   logic [31:0]          key_pool[4];
   cache_scoreboard      sb;

   slru_req_if req_if ();
   slru_rsp_if rsp_if ();

   slru_page_cache_controller_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if.sink),
      .rsp              (rsp_if.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_slru_page_cache_controller_top failed");
         $finish;
      end
   end

   function automatic int draw_wait();
      return quiet ? 0 : $urandom_range(0, 7);
   endfunction

   // check each accepted response word
   always @(posedge clock) begin
      cache_result_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.status = rsp_if.status;
         got.frame_slot = rsp_if.frame_slot;
         got.evicted = rsp_if.evicted;
         got.hit_total = rsp_if.hit_total;
         got.miss_total = rsp_if.miss_total;
         got.eviction_total = rsp_if.eviction_total;
         sb.check_response(got);
      end
   end

   // stall the response side a random number of cycles per word
   initial begin
      int stall;
      rsp_if.ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_if.ready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1;
         do @(posedge clock); while (!rsp_if.valid);
         @(negedge clock);
      end
   end

   // send one request word; starts and ends at a falling edge
   task automatic send_word(input logic [1:0] op, input logic [31:0] obj,
                            input logic [63:0] off, input logic [5:0] rel);
      int gap;
      cache_result_type r;
      gap = draw_wait();
      if (gap > 0) begin
         req_if.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_if.opcode <= op;
      req_if.object_key <= obj;
      req_if.byte_offset <= off;
      req_if.release_slot <= rel;
      req_if.valid <= 1;
      do @(posedge clock); while (!req_if.ready);
      r = sb.note_request(op, obj, off, rel);
      if (op == OP_GET && (r.status == ST_HIT || r.status == ST_MISS))
         held_slots.push_back(int'(r.frame_slot));
      @(negedge clock);
   endtask

   // hold off until every predicted word has come back
   task automatic drain();
      req_if.valid <= 0;
      @(negedge clock);
      while (sb.expected_words.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // raise the write strobe for one cycle; the caller drops it after the last
   task automatic write_reg(input logic [1:0] idx, input logic [20:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      sb.write_reg(idx, val);
      @(negedge clock);
      held_slots.delete();
   endtask

   task automatic configure(input int frm, input int fsz, input int bkt);
      drain();
      write_reg(CSR_FRAMES, 21'(frm));
      write_reg(CSR_FSIZE, 21'(fsz));
      write_reg(CSR_BUCKETS, 21'(bkt));
      csr_write_enable <= 0;
      key_pool[0] = 32'd0;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = $urandom;
      key_pool[3] = $urandom;
   endtask

   // random traffic over a small key and page pool so hits are common
   task automatic random_words(input int count);
      int pick, pages, idx;
      logic [63:0] fs, off;
      logic [31:0] obj;
      logic [5:0] rel;
      logic [1:0] op;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) == 0) quiet = ~quiet;
         fs = sb.page_bytes();
         pages = sb.num_frames() + sb.num_frames() / 2 + 1;
         obj = ($urandom_range(0, 7) == 0) ? $urandom : key_pool[$urandom_range(0, 3)];
         off = 64'($urandom_range(0, pages - 1)) * fs +
               64'($urandom_range(0, int'(fs - 1)));
         if ($urandom_range(0, 7) == 0) off = {$urandom, $urandom};
         rel = 6'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            op = OP_GET;
         end else if (pick < 75) begin
            op = OP_PUT;
            if (held_slots.size() != 0) begin
               idx = $urandom_range(0, held_slots.size() - 1);
               rel = 6'(held_slots[idx]);
               held_slots.delete(idx);
            end
         end else if (pick < 95) begin
            op = (pick < 90) ? OP_PREFETCH : OP_PUT;
         end else begin
            op = OP_NONE;
         end
         send_word(op, obj, off, rel);
      end
   endtask

   initial begin
      sb = new();
      cycle_count = 0;
      quiet = 0;
      reset = 1;
      csr_write_enable = 0;
      csr_index = '0;
      csr_write_data = '0;
      req_if.valid = 0;
      req_if.opcode = OP_GET;
      req_if.object_key = '0;
      req_if.byte_offset = '0;
      req_if.release_slot = '0;
      key_pool = '{32'd0, 32'hFFFF_FFFF, 32'd7, 32'h8000_0000};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: hit within a page, puts good and bad, no-op, extremes
      send_word(OP_GET, 32'd7, 64'd0, 6'd0);
      send_word(OP_GET, 32'd7, 64'd4095, 6'd0);
      send_word(OP_PUT, 32'd0, 64'd0, 6'd0);
      send_word(OP_PUT, 32'd0, 64'd0, 6'd0);
      send_word(OP_PUT, 32'd0, 64'd0, 6'd0);
      send_word(OP_PUT, 32'd0, 64'd0, 6'd63);
      send_word(OP_NONE, 32'hFFFF_FFFF, '1, 6'd63);
      send_word(OP_PREFETCH, 32'hFFFF_FFFF, '1, 6'd0);
      send_word(OP_PREFETCH, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_F000, 6'd0);
      send_word(OP_GET, 32'h8000_0000, 64'h8000_0000_0000_0000, 6'd0);

      // directed: one-frame cache, all pinned, eviction
      configure(1, 1, 1);
      send_word(OP_GET, 32'd1, 64'd10, 6'd0);
      send_word(OP_GET, 32'd1, 64'd10, 6'd0);
      send_word(OP_GET, 32'd2, 64'd10, 6'd0);
      send_word(OP_PREFETCH, 32'd2, 64'd10, 6'd0);
      send_word(OP_PUT, 32'd0, 64'd0, 6'd0);
      send_word(OP_PUT, 32'd0, 64'd0, 6'd0);
      send_word(OP_PUT, 32'd0, 64'd0, 6'd0);
      send_word(OP_PUT, 32'd0, 64'd0, 6'd1);
      send_word(OP_GET, 32'd2, 64'd10, 6'd0);
      send_word(OP_PREFETCH, 32'd1, 64'd10, 6'd0);
      held_slots.delete();

      configure(64, 4096, 64);
      random_words(200);
      configure(1, 1, 1);
      random_words(150);
      configure(2, 1048576, 1);
      random_words(180);
      configure(4, 3, 64);
      random_words(180);
      configure(0, 0, 0);
      random_words(120);
      configure(127, 2097151, 127);
      random_words(200);
      configure(8, 512, 5);
      random_words(200);
      configure(16, 1, 64);
      random_words(180);
      configure(3, 4096, 2);
      random_words(150);
      configure(64, 1, 13);
      random_words(190);

      // wait out the remaining responses
      req_if.valid <= 0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
         $display("tb_slru_page_cache_controller_top passed");
      end else begin
         $display("tb_slru_page_cache_controller_top failed");
      end
      $finish;
   end

endmodule
